### hdl/ffa_pkg.sv
package ffa_pkg;

	localparam int PAGE_BYTES_DEF   = 4096;
	localparam int HEADER_BYTES_DEF = 32;
	localparam int MAX_PAGES_DEF    = 16;
	localparam int MAX_BLOCKS_DEF   = 256;

	localparam int PAGES_W = 5;
	localparam int REQ_W   = 17;
	localparam int OFF_W   = 16;

	typedef enum logic {
		ACT_ALLOC = 1'b0,
		ACT_FREE  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BAD    = 2'd1,
		ST_UNINIT = 2'd2,
		ST_OOM    = 2'd3
	} status_t;

	typedef struct packed {
		logic [OFF_W-1:0] granted_offset;
		status_t          status;
	} result_t;

endpackage

### hdl/ffa_if.sv
interface ffa_req_if import ffa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              action;
	logic [REQ_W-1:0]  request_bytes;
	logic [OFF_W-1:0]  data_offset;

	modport source (output valid, action, request_bytes, data_offset, input ready);
	modport sink (input valid, action, request_bytes, data_offset, output ready);
endinterface

interface ffa_rsp_if import ffa_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OFF_W-1:0]  granted_offset;
	logic [1:0]        status;

	modport source (output valid, granted_offset, status, input ready);
	modport sink (input valid, granted_offset, status, output ready);
endinterface

### hdl/ffa_rec_mem.sv
module ffa_rec_mem #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 51
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hdl/ffa_ctrl.sv
module ffa_ctrl import ffa_pkg::*; #(
	parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int MAX_PAGES    = MAX_PAGES_DEF,
	parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
	parameter int SLOT_W       = $clog2(MAX_BLOCKS),
	parameter int LEN_W        = $clog2(MAX_PAGES * PAGE_BYTES),
	parameter int REC_W        = 2 * LEN_W + 1 + 2 * (SLOT_W + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  logic               cmd_action,
	input  logic [REQ_W-1:0]   cmd_request_bytes,
	input  logic [OFF_W-1:0]   cmd_data_offset,
	input  logic               cfg_we,
	input  logic [PAGES_W-1:0] cfg_wdata,
	input  logic               out_free,
	output logic               done,
	output result_t            res,
	output logic               mem_we,
	output logic [SLOT_W-1:0]  mem_waddr,
	output logic [REC_W-1:0]   mem_wdata,
	output logic [SLOT_W-1:0]  mem_raddr,
	input  logic [REC_W-1:0]   mem_rdata
);

	localparam int LINK_W = SLOT_W + 1;
	localparam int RQ_W   = LEN_W + 1;
	localparam int CMP_W  = LEN_W + 2;
	localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_BLOCKS);
	localparam logic [CMP_W-1:0] HDR = CMP_W'(HEADER_BYTES);
	localparam logic [31:0] MAX_REQ = 32'(MAX_PAGES * PAGE_BYTES);

	typedef struct packed {
		logic [LEN_W-1:0]  start;
		logic [LEN_W-1:0]  len;
		logic              free;
		logic [LINK_W-1:0] nxt;
		logic [LINK_W-1:0] prv;
	} rec_t;

	typedef enum logic [14:0] {
		S_IDLE  = 15'b000000000000001,
		S_AREAD = 15'b000000000000010,
		S_ACHK  = 15'b000000000000100,
		S_SCAN  = 15'b000000000001000,
		S_WNS   = 15'b000000000010000,
		S_FREAD = 15'b000000000100000,
		S_FCHK  = 15'b000000001000000,
		S_NREAD = 15'b000000010000000,
		S_NCHK  = 15'b000000100000000,
		S_PREAD = 15'b000001000000000,
		S_PCHK  = 15'b000010000000000,
		S_WREC  = 15'b000100000000000,
		S_FIXRD = 15'b001000000000000,
		S_FIXWR = 15'b010000000000000,
		S_DONE  = 15'b100000000000000
	} state_t;

	state_t                  state_q;
	logic [MAX_BLOCKS-1:0]   used_q;
	logic [LINK_W-1:0]       head_q;
	logic [PAGES_W-1:0]      pages_q;
	logic [LINK_W-1:0]       cur_q;
	logic [LINK_W-1:0]       steps_q;
	logic                    act_q;
	logic [RQ_W-1:0]         req_q;
	logic [OFF_W-1:0]        off_q;
	rec_t                    rec_q;
	logic [SLOT_W-1:0]       blk_q;
	logic [SLOT_W-1:0]       ns_q;
	logic [SLOT_W-1:0]       scan_q;
	logic                    merged_q;
	logic [SLOT_W-1:0]       wr_addr_q;
	rec_t                    wr_rec_q;
	logic [LINK_W-1:0]       fix_q;
	logic [LINK_W-1:0]       fix_prev_q;
	logic                    fix_en_q;
	logic [OFF_W-1:0]        grant_q;
	status_t                 status_q;

	rec_t                    rd;
	rec_t                    init_rec;
	rec_t                    fix_rec;
	logic [PAGES_W-1:0]      sat_pages;
	logic [CMP_W-1:0]        rd_len_c;
	logic [CMP_W-1:0]        req_c;
	logic [OFF_W-1:0]        rec_grant;

	function automatic logic live(input logic [LINK_W-1:0] s, input logic [MAX_BLOCKS-1:0] u);
		return (s < NIL) && u[s[SLOT_W-1:0]];
	endfunction

	assign rd        = rec_t'(mem_rdata);
	assign sat_pages = (cfg_wdata > PAGES_W'(MAX_PAGES)) ? PAGES_W'(MAX_PAGES) : cfg_wdata;
	assign rd_len_c  = CMP_W'(rd.len);
	assign req_c     = CMP_W'(req_q);
	assign rec_grant = OFF_W'(CMP_W'(rd.start) + HDR);

	always_comb begin
		init_rec       = '0;
		init_rec.len   = LEN_W'(32'(sat_pages) * 32'(PAGE_BYTES) - 32'(HEADER_BYTES));
		init_rec.free  = 1'b1;
		init_rec.nxt   = NIL;
		init_rec.prv   = NIL;
		fix_rec        = rd;
		fix_rec.prv    = fix_prev_q;
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wr_addr_q;
		mem_wdata = REC_W'(wr_rec_q);
		mem_raddr = cur_q[SLOT_W-1:0];
		case (state_q)
			S_NREAD: mem_raddr = rec_q.nxt[SLOT_W-1:0];
			S_PREAD: mem_raddr = rec_q.prv[SLOT_W-1:0];
			S_FIXRD: mem_raddr = fix_q[SLOT_W-1:0];
			S_WNS: begin
				mem_we    = 1'b1;
				mem_waddr = ns_q;
				mem_wdata = REC_W'({LEN_W'(CMP_W'(rec_q.start) + HDR + req_c),
					LEN_W'(CMP_W'(rec_q.len) - req_c - HDR), 1'b1, rec_q.nxt,
					LINK_W'(blk_q)});
			end
			S_WREC: mem_we = 1'b1;
			S_FIXWR: begin
				mem_we    = 1'b1;
				mem_waddr = fix_q[SLOT_W-1:0];
				mem_wdata = REC_W'(fix_rec);
			end
			default: ;
		endcase
		if (cfg_we) begin
			mem_we    = 1'b1;
			mem_waddr = '0;
			mem_wdata = REC_W'(init_rec);
		end
	end

	assign cmd_ready = (state_q == S_IDLE);
	assign done      = (state_q == S_DONE) && out_free;
	assign res       = '{granted_offset: grant_q, status: status_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
			head_q  <= NIL;
			pages_q <= '0;
			steps_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						act_q    <= cmd_action;
						req_q    <= RQ_W'(cmd_request_bytes);
						off_q    <= cmd_data_offset;
						cur_q    <= head_q;
						steps_q  <= '0;
						grant_q  <= '0;
						status_q <= ST_OK;
						if (cmd_action == ACT_ALLOC) begin
							if (pages_q == '0) begin
								status_q <= ST_UNINIT;
								state_q  <= S_DONE;
							end else if (cmd_request_bytes == '0 ||
								32'(cmd_request_bytes) > MAX_REQ) begin
								status_q <= ST_BAD;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_AREAD;
							end
						end else begin
							if (cmd_data_offset == '0) begin
								state_q <= S_DONE;
							end else if (pages_q == '0) begin
								status_q <= ST_UNINIT;
								state_q  <= S_DONE;
							end else begin
								state_q <= S_FREAD;
							end
						end
					end
				end
				S_AREAD: begin
					if (steps_q == NIL || !live(cur_q, used_q)) begin
						status_q <= ST_OOM;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_ACHK;
					end
				end
				S_ACHK: begin
					rec_q <= rd;
					blk_q <= cur_q[SLOT_W-1:0];
					if (rd.free && rd_len_c >= req_c) begin
						grant_q <= rec_grant;
						if (rd_len_c > req_c + HDR && !(&used_q)) begin
							scan_q  <= '0;
							state_q <= S_SCAN;
						end else begin
							wr_rec_q  <= '{start: rd.start, len: rd.len, free: 1'b0,
								nxt: rd.nxt, prv: rd.prv};
							wr_addr_q <= cur_q[SLOT_W-1:0];
							fix_en_q  <= 1'b0;
							state_q   <= S_WREC;
						end
					end else begin
						cur_q   <= rd.nxt;
						steps_q <= steps_q + 1'b1;
						state_q <= S_AREAD;
					end
				end
				S_SCAN: begin
					if (!used_q[scan_q]) begin
						ns_q           <= scan_q;
						used_q[scan_q] <= 1'b1;
						state_q        <= S_WNS;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_WNS: begin
					wr_rec_q   <= '{start: rec_q.start, len: LEN_W'(req_q), free: 1'b0,
						nxt: LINK_W'(ns_q), prv: rec_q.prv};
					wr_addr_q  <= blk_q;
					fix_q      <= rec_q.nxt;
					fix_prev_q <= LINK_W'(ns_q);
					fix_en_q   <= 1'b1;
					state_q    <= S_WREC;
				end
				S_FREAD: begin
					if (steps_q == NIL || !live(cur_q, used_q)) begin
						status_q <= ST_BAD;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_FCHK;
					end
				end
				S_FCHK: begin
					if (32'(rd.start) + 32'(HEADER_BYTES) == 32'(off_q)) begin
						if (rd.free) begin
							status_q <= ST_BAD;
							state_q  <= S_DONE;
						end else begin
							rec_q    <= '{start: rd.start, len: rd.len, free: 1'b1,
								nxt: rd.nxt, prv: rd.prv};
							blk_q    <= cur_q[SLOT_W-1:0];
							merged_q <= 1'b0;
							state_q  <= S_NREAD;
						end
					end else begin
						cur_q   <= rd.nxt;
						steps_q <= steps_q + 1'b1;
						state_q <= S_FREAD;
					end
				end
				S_NREAD: begin
					state_q <= live(rec_q.nxt, used_q) ? S_NCHK : S_PREAD;
				end
				S_NCHK: begin
					if (rd.free) begin
						rec_q <= '{start: rec_q.start,
							len: LEN_W'(CMP_W'(rec_q.len) + rd_len_c + HDR),
							free: rec_q.free, nxt: rd.nxt, prv: rec_q.prv};
						used_q[rec_q.nxt[SLOT_W-1:0]] <= 1'b0;
						merged_q  <= 1'b1;
					end
					state_q <= S_PREAD;
				end
				S_PREAD: begin
					if (live(rec_q.prv, used_q)) begin
						state_q <= S_PCHK;
					end else begin
						wr_addr_q  <= blk_q;
						wr_rec_q   <= rec_q;
						fix_q      <= rec_q.nxt;
						fix_prev_q <= LINK_W'(blk_q);
						fix_en_q   <= merged_q;
						state_q    <= S_WREC;
					end
				end
				S_PCHK: begin
					fix_q <= rec_q.nxt;
					if (rd.free) begin
						wr_addr_q     <= rec_q.prv[SLOT_W-1:0];
						wr_rec_q      <= '{start: rd.start,
							len: LEN_W'(rd_len_c + CMP_W'(rec_q.len) + HDR),
							free: rd.free, nxt: rec_q.nxt, prv: rd.prv};
						used_q[blk_q] <= 1'b0;
						fix_prev_q    <= rec_q.prv;
						fix_en_q      <= 1'b1;
					end else begin
						wr_addr_q  <= blk_q;
						wr_rec_q   <= rec_q;
						fix_prev_q <= LINK_W'(blk_q);
						fix_en_q   <= merged_q;
					end
					state_q <= S_WREC;
				end
				S_WREC: begin
					state_q <= (fix_en_q && live(fix_q, used_q)) ? S_FIXRD : S_DONE;
				end
				S_FIXRD: state_q <= S_FIXWR;
				S_FIXWR: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg_we) begin
				pages_q <= sat_pages;
				used_q  <= MAX_BLOCKS'(sat_pages != '0);
				head_q  <= (sat_pages != '0) ? '0 : NIL;
			end
		end
	end

	a_scan_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> !(&used_q))
		else $error("slot scan started with every record slot in use");

	a_steps_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		steps_q <= NIL)
		else $error("list walk went past the record count");

	a_grant_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status_q == ST_OK && act_q == ACT_ALLOC |-> grant_q != '0)
		else $error("successful allocation returned a null offset");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_wdata != '0 |=> used_q[0] && head_q == '0)
		else $error("arena rebuild did not create the first block");

endmodule

### hdl/first_fit_block_allocator.sv
// First-fit block allocator with coalescing over an arena of whole pages.
// Requests arrive as words on the req channel (valid/ready): action selects
// allocate or free, request_bytes is the size wanted, data_offset names the
// block to free. Each request produces exactly one word on the rsp channel
// carrying granted_offset and status.
// The arena is set up by writing the page count on cfg_we/cfg_wdata while the
// block is idle; a nonzero write rebuilds a single free block.
// Each request walks the block list one record at a time through the record
// memory (a read state, then a check state per record); a split that needs a
// new record slot also scans the record map one slot at a time, and a free
// then checks both neighbours for merging and fixes the next block's back link.
// The response sits in an output register; the next request is taken while
// it waits, but a finished request holds until the receiver takes the word.
// Reset clears the arena to the uninitialized state and the record map; no
// clearing pass over the memory is needed.
module first_fit_block_allocator import ffa_pkg::*; #(
	parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int MAX_PAGES    = MAX_PAGES_DEF,
	parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	ffa_req_if.sink            req,
	ffa_rsp_if.source          rsp,
	input  logic               cfg_we,
	input  logic [PAGES_W-1:0] cfg_wdata
);

	localparam int SLOT_W = $clog2(MAX_BLOCKS);
	localparam int LEN_W  = $clog2(MAX_PAGES * PAGE_BYTES);
	localparam int REC_W  = 2 * LEN_W + 1 + 2 * (SLOT_W + 1);

	logic              out_valid_q;
	result_t           out_q;
	logic              out_free;
	logic              done;
	result_t           res;
	logic              mem_we;
	logic [SLOT_W-1:0] mem_waddr;
	logic [REC_W-1:0]  mem_wdata;
	logic [SLOT_W-1:0] mem_raddr;
	logic [REC_W-1:0]  mem_rdata;

	assign out_free = !out_valid_q || rsp.ready;

	ffa_ctrl #(
		.PAGE_BYTES  (PAGE_BYTES),
		.HEADER_BYTES(HEADER_BYTES),
		.MAX_PAGES   (MAX_PAGES),
		.MAX_BLOCKS  (MAX_BLOCKS),
		.SLOT_W      (SLOT_W),
		.LEN_W       (LEN_W),
		.REC_W       (REC_W)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd_valid        (req.valid),
		.cmd_ready        (req.ready),
		.cmd_action       (req.action),
		.cmd_request_bytes(req.request_bytes),
		.cmd_data_offset  (req.data_offset),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.out_free         (out_free),
		.done             (done),
		.res              (res),
		.mem_we           (mem_we),
		.mem_waddr        (mem_waddr),
		.mem_wdata        (mem_wdata),
		.mem_raddr        (mem_raddr),
		.mem_rdata        (mem_rdata)
	);

	ffa_rec_mem #(
		.DEPTH(MAX_BLOCKS),
		.WIDTH(REC_W)
	) u_rec_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_q <= res;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.granted_offset = out_q.granted_offset;
	assign rsp.status         = out_q.status;

endmodule
